@@ hdl/mbp_pkg.sv @@
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int unsigned MaxBytesDefault = 256;
  localparam int unsigned ValueW          = 64;
  localparam int unsigned WidthW          = 7;
  localparam int unsigned ByteCntW        = 9;
  localparam int unsigned WorkW           = ValueW + 8;
  // Widths up to this append every bit; wider ones append whole bytes only.
  localparam int unsigned FullBitsLimit   = 16;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  // One classified item as it waits between front and back.
  typedef struct packed {
    cmd_e              cmd;
    logic [WidthW-1:0] nbits;
    logic [ValueW-1:0] value;
  } entry_t;

endpackage

@@ hdl/mbp_if.sv @@
// Handshake channel interfaces for the packer's input items and result bytes.
interface mbp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [mbp_pkg::WidthW-1:0]          field_width;
  logic [mbp_pkg::ValueW-1:0]          field_value;

  modport source (output valid, output command, output field_width, output field_value,
                  input ready);
  modport sink   (input valid, input command, input field_width, input field_value,
                  output ready);
endinterface

interface mbp_out_if;
  logic                                valid;
  logic                                ready;
  logic [7:0]                          out_byte;
  logic                                byte_valid;
  logic                                last;
  logic [mbp_pkg::ByteCntW-1:0]        byte_count;
  logic                                overflow;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output byte_count, output overflow, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input byte_count, input overflow, output ready);
endinterface

@@ hdl/mbp_front.sv @@
// Front end: takes input items and reduces the declared width to the bit count appended.
module mbp_front (
  mbp_in_if.sink          in_i,
  output mbp_pkg::entry_t entry_o,
  output logic            push_o,
  input  logic            full_i
);
  import mbp_pkg::*;

  logic [WidthW-1:0] width_clamped;

  always_comb begin
    width_clamped = (in_i.field_width > WidthW'(ValueW)) ? WidthW'(ValueW) : in_i.field_width;
    entry_o.cmd   = cmd_e'(in_i.command);
    entry_o.value = in_i.field_value;
    if (width_clamped <= WidthW'(FullBitsLimit)) begin
      entry_o.nbits = width_clamped;
    end else begin
      entry_o.nbits = {width_clamped[WidthW-1:3], 3'b000};
    end
  end

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

@@ hdl/mbp_fifo.sv @@
// Two-entry queue that decouples the front end from the byte emitter.
module mbp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbp_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output mbp_pkg::entry_t entry_o,
  output logic            valid_o
);
  import mbp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            slot_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ hdl/mbp_back.sv @@
// Back end: merges field bits with the pending byte and emits packed bytes one per cycle unless output stalls.
module mbp_back #(
  parameter int unsigned MAX_BYTES = mbp_pkg::MaxBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbp_pkg::entry_t entry_i,
  input  logic            valid_i,
  output logic            pop_o,
  mbp_out_if.source       out_o
);
  import mbp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

  // Byte splitter
  logic               busy_q, busy_d;
  logic [WorkW-1:0]   work_q, work_d;
  logic [WidthW-1:0]  rem_q, rem_d;
  // Record state; pending bits are kept left aligned with zero fill
  logic [7:0]         pend_q, pend_d;
  logic [2:0]         pcnt_q, pcnt_d;
  logic [CntW-1:0]    bytes_q, bytes_d;
  logic               ovf_q, ovf_d;
  // Output register
  logic               ovalid_q, ovalid_d;
  logic [7:0]         obyte_q, obyte_d;
  logic               obv_q, obv_d;
  logic               olast_q, olast_d;
  logic [CntW-1:0]    ocnt_q, ocnt_d;
  logic               oovf_q, oovf_d;

  logic               out_free;
  logic               room;
  logic [ValueW-1:0]  vshift;
  logic [WorkW-1:0]   merged;
  logic [WidthW-1:0]  total;
  logic               emit;
  logic [7:0]         emit_byte;
  logic               emit_last;

  assign out_free = !ovalid_q || out_o.ready;
  assign room     = (bytes_q < CntW'(MAX_BYTES));

  always_comb begin
    vshift = entry_i.value << (WidthW'(ValueW) - entry_i.nbits);
    merged = {pend_q, {ValueW{1'b0}}} | ({vshift, 8'h00} >> pcnt_q);
    total  = WidthW'(pcnt_q) + entry_i.nbits;
  end

  always_comb begin
    busy_d    = busy_q;
    work_d    = work_q;
    rem_d     = rem_q;
    pend_d    = pend_q;
    pcnt_d    = pcnt_q;
    bytes_d   = bytes_q;
    ovf_d     = ovf_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    obyte_d   = obyte_q;
    obv_d     = obv_q;
    olast_d   = olast_q;
    ocnt_d    = ocnt_q;
    oovf_d    = oovf_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;

    priority if (busy_q) begin
      if (out_free) begin
        emit      = 1'b1;
        emit_byte = work_q[WorkW-1 -: 8];
        emit_last = (rem_q < WidthW'(16));
        work_d    = work_q << 8;
        rem_d     = rem_q - WidthW'(8);
        if (emit_last) begin
          busy_d = 1'b0;
          pend_d = work_q[WorkW-9 -: 8];
          pcnt_d = rem_q[2:0];
        end
      end
    end else if (valid_i) begin
      unique case (entry_i.cmd)
        CMD_APPEND: begin
          pop_o = 1'b1;
          if (total >= WidthW'(8)) begin
            busy_d = 1'b1;
            work_d = merged;
            rem_d  = total;
          end else begin
            pend_d = merged[WorkW-1 -: 8];
            pcnt_d = total[2:0];
          end
        end
        CMD_FINISH: begin
          if (out_free) begin
            pop_o = 1'b1;
            if (pcnt_q != 3'd0) begin
              emit      = 1'b1;
              emit_byte = pend_q;
              emit_last = 1'b1;
            end else begin
              ovalid_d = 1'b1;
              obyte_d  = 8'h00;
              obv_d    = 1'b0;
              olast_d  = 1'b1;
              ocnt_d   = bytes_q;
              oovf_d   = ovf_q;
            end
          end
        end
        default: ;
      endcase
    end

    if (emit) begin
      ovalid_d = 1'b1;
      olast_d  = emit_last;
      obv_d    = room;
      obyte_d  = room ? emit_byte : 8'h00;
      ocnt_d   = room ? bytes_q + 1'b1 : bytes_q;
      oovf_d   = ovf_q || !room;
      bytes_d  = ocnt_d;
      ovf_d    = oovf_d;
    end

    // Finish clears the record once its result is queued
    if (pop_o && entry_i.cmd == CMD_FINISH) begin
      pend_d  = 8'h00;
      pcnt_d  = 3'd0;
      bytes_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rem_q    <= '0;
      pend_q   <= 8'h00;
      pcnt_q   <= 3'd0;
      bytes_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      rem_q    <= rem_d;
      pend_q   <= pend_d;
      pcnt_q   <= pcnt_d;
      bytes_q  <= bytes_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    obyte_q <= obyte_d;
    obv_q   <= obv_d;
    olast_q <= olast_d;
    ocnt_q  <= ocnt_d;
    oovf_q  <= oovf_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = obyte_q;
  assign out_o.byte_valid = obv_q;
  assign out_o.last       = olast_q;
  assign out_o.byte_count = ByteCntW'(ocnt_q);
  assign out_o.overflow   = oovf_q;

`ifndef NO_ASSERTIONS
  a_busy_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q >= WidthW'(8) && rem_q <= WidthW'(WorkW - 1)))
    else $error("splitter busy without a whole byte left");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= CntW'(MAX_BYTES))
    else $error("record byte count above capacity");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.cmd == CMD_FINISH) |=> (bytes_q == '0 && !ovf_q && pcnt_q == 3'd0))
    else $error("finish did not clear the record");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop_o)
    else $error("queue popped while bytes still being split");
`endif

endmodule

@@ hdl/msb_first_bit_packer_top.sv @@
// MSB-first bit packer: append items add the low bits of a field (all bits for widths up to
// 16, whole bytes of the width above that, widths over 64 count as 64) to a byte stream and
// every completed byte comes out as one transaction; a finish item flushes the partial byte
// left aligned, reports the record's byte count and clears the packer. Bytes beyond MAX_BYTES
// are still reported but with byte_valid low and the sticky overflow flag set. A two-entry
// queue sits between input and emitter. The emitter hands out one byte per cycle through its
// output register while the consumer takes them; an append completes up to 8 bytes, and the
// emitter takes no new item from the queue until all of them are out.
module msb_first_bit_packer_top #(
  parameter int unsigned MAX_BYTES = mbp_pkg::MaxBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbp_in_if.sink    in_i,
  mbp_out_if.source out_o
);
  import mbp_pkg::*;

  entry_t front_entry;
  entry_t queue_entry;
  logic   push;
  logic   full;
  logic   pop;
  logic   queue_valid;

  mbp_front u_front (
    .in_i    (in_i),
    .entry_o (front_entry),
    .push_o  (push),
    .full_i  (full)
  );

  mbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .valid_o (queue_valid)
  );

  mbp_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (queue_entry),
    .valid_i (queue_valid),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
